// ===== hw/rtl/derb_pkg.sv =====
// ----------------------------------------------------------------------------
// derb_pkg
// Shared sizes, action codes, control types and ring pointer helpers for the
// double-ended ring buffer.
// ----------------------------------------------------------------------------
package derb_pkg;

	localparam int DEPTH  = 16;
	localparam int ITEM_W = 32;
	localparam int PTR_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int ACT_W  = 4;

	localparam logic [ACT_W-1:0] ACT_PUSH_BACK      = 4'd0;
	localparam logic [ACT_W-1:0] ACT_PUSH_FRONT     = 4'd1;
	localparam logic [ACT_W-1:0] ACT_PUSH_BACK_OVW  = 4'd2;
	localparam logic [ACT_W-1:0] ACT_PUSH_FRONT_OVW = 4'd3;
	localparam logic [ACT_W-1:0] ACT_POP_BACK       = 4'd4;
	localparam logic [ACT_W-1:0] ACT_POP_FRONT      = 4'd5;
	localparam logic [ACT_W-1:0] ACT_PEEK           = 4'd6;
	localparam logic [ACT_W-1:0] ACT_READ_RUN       = 4'd7;
	localparam logic [ACT_W-1:0] ACT_CLEAR          = 4'd8;

	// controller -> datapath
	typedef struct packed {
		logic load;   // latch a new word
		logic exec;   // carry out the latched action
		logic step;   // advance a run read by one word
	} derb_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic last;   // word on the result ports is the final one
	} derb_stat_t;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p,
			input logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] n;
		n = CNT_W'(p) + CNT_W'(1);
		return (n >= cap) ? '0 : n[PTR_W-1:0];
	endfunction

	function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p,
			input logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] n;
		n = (p == '0) ? cap - CNT_W'(1) : CNT_W'(p) - CNT_W'(1);
		return n[PTR_W-1:0];
	endfunction

	// slot of the item at offset off from the front; front + off < 2 * cap
	function automatic logic [PTR_W-1:0] ptr_slot(input logic [PTR_W-1:0] front,
			input logic [CNT_W-1:0] off, input logic [CNT_W-1:0] cap);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(front) + (CNT_W+1)'(off);
		if (s >= (CNT_W+1)'(cap)) begin
			s = s - (CNT_W+1)'(cap);
		end
		return s[PTR_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/derb_ctrl.sv =====
// ----------------------------------------------------------------------------
// derb_ctrl
// Sequencer: accept, execute, then present one or more result words.
// ----------------------------------------------------------------------------
module derb_ctrl import derb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  derb_stat_t stat,
	output derb_cmd_t  cmd,
	output logic       busy,
	output logic       done
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       free;

	// free to take a word when idle or showing the final result
	assign free = (state_q == ST_IDLE) || ((state_q == ST_OUT) && stat.last);
	assign busy = !free;
	assign done = (state_q == ST_OUT);

	always_comb begin
		cmd.load = start && free;
		cmd.exec = (state_q == ST_EXEC);
		cmd.step = (state_q == ST_OUT) && !stat.last;
		state_d  = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (stat.last) state_d = start ? ST_EXEC : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hw/rtl/derb_dp.sv =====
// ----------------------------------------------------------------------------
// derb_dp
// Datapath: item store, ring pointers, capacity register, run counters and
// result registers.
// ----------------------------------------------------------------------------
module derb_dp import derb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  derb_cmd_t         cmd,
	output derb_stat_t        stat,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_data,
	input  logic [ACT_W-1:0]  action,
	input  logic [ITEM_W-1:0] data_in,
	input  logic [PTR_W-1:0]  index,
	input  logic [CNT_W-1:0]  run_length,
	output logic              ok,
	output logic [ITEM_W-1:0] data_out,
	output logic              data_valid,
	output logic              evicted,
	output logic [CNT_W-1:0]  count_after,
	output logic              last
);

	logic [ITEM_W-1:0] mem [DEPTH];
	logic [ITEM_W-1:0] rd_data_q;

	// latched word
	logic [ACT_W-1:0]  act_q;
	logic [ITEM_W-1:0] din_q;
	logic [PTR_W-1:0]  idx_q;
	logic [CNT_W-1:0]  len_q;

	// ring state
	logic [PTR_W-1:0]  front_q, back_q;
	logic [CNT_W-1:0]  count_q, cap_q;

	// run read progress
	logic [CNT_W-1:0]  off_q, rem_q;

	// result word
	logic              res_ok_q, res_valid_q, res_ev_q, res_last_q;
	logic [CNT_W-1:0]  res_count_q;

	// next-state terms for an executed action
	logic [PTR_W-1:0]  front_n, back_n, f1, rd_addr, wr_addr;
	logic [CNT_W-1:0]  count_n, c1, off_n, rem_n, cap_clamp;
	logic              wr_en, ok_n, valid_n, ev_n, last_n, full;
	logic              run_bad;

	assign full = (count_q >= cap_q);
	assign run_bad = (CNT_W'(idx_q) >= count_q) ||
		((CNT_W+1)'(idx_q) + (CNT_W+1)'(len_q) > (CNT_W+1)'(count_q));

	always_comb begin
		if (cfg_data == '0) begin
			cap_clamp = CNT_W'(1);
		end else if (cfg_data > CNT_W'(DEPTH)) begin
			cap_clamp = CNT_W'(DEPTH);
		end else begin
			cap_clamp = cfg_data;
		end
	end

	always_comb begin
		front_n = front_q;
		back_n  = back_q;
		count_n = count_q;
		wr_en   = 1'b0;
		wr_addr = back_q;
		rd_addr = ptr_slot(front_q, off_q, cap_q);
		ok_n    = 1'b0;
		valid_n = 1'b0;
		ev_n    = 1'b0;
		last_n  = 1'b1;
		off_n   = off_q;
		rem_n   = rem_q;
		// evict the front first when an overwrite push finds the ring full
		f1      = full ? ptr_inc(front_q, cap_q) : front_q;
		c1      = full ? count_q - CNT_W'(1) : count_q;
		case (act_q)
			ACT_PUSH_BACK: begin
				if (!full) begin
					ok_n    = 1'b1;
					wr_en   = 1'b1;
					wr_addr = back_q;
					back_n  = ptr_inc(back_q, cap_q);
					count_n = count_q + CNT_W'(1);
				end
			end
			ACT_PUSH_FRONT: begin
				if (!full) begin
					ok_n    = 1'b1;
					wr_en   = 1'b1;
					front_n = ptr_dec(front_q, cap_q);
					wr_addr = front_n;
					count_n = count_q + CNT_W'(1);
				end
			end
			ACT_PUSH_BACK_OVW: begin
				ok_n    = 1'b1;
				valid_n = full;
				ev_n    = full;
				rd_addr = front_q;
				front_n = f1;
				wr_en   = 1'b1;
				wr_addr = back_q;
				back_n  = ptr_inc(back_q, cap_q);
				count_n = c1 + CNT_W'(1);
			end
			ACT_PUSH_FRONT_OVW: begin
				// on eviction this lands in the slot the old head held
				ok_n    = 1'b1;
				valid_n = full;
				ev_n    = full;
				rd_addr = front_q;
				front_n = ptr_dec(f1, cap_q);
				wr_en   = 1'b1;
				wr_addr = front_n;
				count_n = c1 + CNT_W'(1);
			end
			ACT_POP_BACK: begin
				if (count_q != '0) begin
					ok_n    = 1'b1;
					valid_n = 1'b1;
					back_n  = ptr_dec(back_q, cap_q);
					rd_addr = back_n;
					count_n = count_q - CNT_W'(1);
				end
			end
			ACT_POP_FRONT: begin
				if (count_q != '0) begin
					ok_n    = 1'b1;
					valid_n = 1'b1;
					rd_addr = front_q;
					front_n = ptr_inc(front_q, cap_q);
					count_n = count_q - CNT_W'(1);
				end
			end
			ACT_PEEK: begin
				ok_n    = (CNT_W'(idx_q) < count_q);
				valid_n = ok_n;
				rd_addr = ptr_slot(front_q, CNT_W'(idx_q), cap_q);
			end
			ACT_READ_RUN: begin
				ok_n    = !run_bad;
				// first word at the start index, later words at the run offset
				rd_addr = cmd.step ? ptr_slot(front_q, off_q, cap_q) :
					ptr_slot(front_q, CNT_W'(idx_q), cap_q);
				if (!run_bad && (len_q != '0)) begin
					valid_n = 1'b1;
					last_n  = (len_q == CNT_W'(1));
					rem_n   = len_q;
					off_n   = CNT_W'(idx_q) + CNT_W'(1);
				end
			end
			ACT_CLEAR: begin
				ok_n    = 1'b1;
				front_n = '0;
				back_n  = '0;
				count_n = '0;
			end
			default: begin
				ok_n = 1'b0;
			end
		endcase
	end

	// store: read before write on a shared address
	always_ff @(posedge clk) begin
		if (cmd.exec || cmd.step) begin
			rd_data_q <= mem[rd_addr];
		end
		if (cmd.exec && wr_en) begin
			mem[wr_addr] <= din_q;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action;
			din_q <= data_in;
			idx_q <= index;
			len_q <= run_length;
		end
		if (cmd.exec) begin
			off_q       <= off_n;
			rem_q       <= rem_n;
			res_ok_q    <= ok_n;
			res_valid_q <= valid_n;
			res_ev_q    <= ev_n;
			res_count_q <= count_n;
		end else if (cmd.step) begin
			off_q <= off_q + CNT_W'(1);
			rem_q <= rem_q - CNT_W'(1);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q    <= '0;
			back_q     <= '0;
			count_q    <= '0;
			cap_q      <= CNT_W'(DEPTH);
			res_last_q <= 1'b1;
		end else begin
			if (cfg_we) begin
				cap_q   <= cap_clamp;
				front_q <= '0;
				back_q  <= '0;
				count_q <= '0;
			end else if (cmd.exec) begin
				front_q <= front_n;
				back_q  <= back_n;
				count_q <= count_n;
			end
			if (cmd.exec) begin
				res_last_q <= last_n;
			end else if (cmd.step) begin
				res_last_q <= (rem_q == CNT_W'(2));
			end
		end
	end

	assign stat.last   = res_last_q;
	assign ok          = res_ok_q;
	assign data_valid  = res_valid_q;
	assign data_out    = res_valid_q ? rd_data_q : '0;
	assign evicted     = res_ev_q;
	assign count_after = res_count_q;
	assign last        = res_last_q;

endmodule

// ===== hw/rtl/double_ended_ring_buffer.sv =====
// ----------------------------------------------------------------------------
// double_ended_ring_buffer
// Deque of 32-bit items on a ring of 16 slots, with push/pop at both ends,
// overwrite pushes, peek, run reads and clear.
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------------
//  command  | start / busy          | action, data_in, index, run_length
//  result   | done (each result)    | ok, data_out, data_valid, evicted,
//           |                       | count_after, last
//  config   | cfg_we                | cfg_data (capacity_in_use)
//
// A word is taken on an edge with start high and busy low. It then passes
// through execute (ring update plus store read); its result is then on the
// ports for one cycle with done high. A run read of N words gives N results
// on consecutive cycles, one store read each. Back-to-back words therefore
// alternate between execute and result, since the store read is registered.
// busy drops during the final result so the next word is taken there.
// Reset empties the ring and sets capacity to 16; the store is not cleared.
// Results cannot be held off; a config write also empties the ring.
//
module double_ended_ring_buffer import derb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// command
	input  logic              start,
	output logic              busy,
	input  logic [ACT_W-1:0]  action,
	input  logic [ITEM_W-1:0] data_in,
	input  logic [PTR_W-1:0]  index,
	input  logic [CNT_W-1:0]  run_length,
	// config
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_data,
	// result
	output logic              done,
	output logic              ok,
	output logic [ITEM_W-1:0] data_out,
	output logic              data_valid,
	output logic              evicted,
	output logic [CNT_W-1:0]  count_after,
	output logic              last
);

	derb_cmd_t  cmd;
	derb_stat_t stat;

	// sequencer
	derb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// store, pointers and result registers
	derb_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.action      (action),
		.data_in     (data_in),
		.index       (index),
		.run_length  (run_length),
		.ok          (ok),
		.data_out    (data_out),
		.data_valid  (data_valid),
		.evicted     (evicted),
		.count_after (count_after),
		.last        (last)
	);

endmodule
